[hdl/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// Six-bit decoder package
// Shared commands, class codes and result types for the six-bit text decoder.
// ----------------------------------------------------------------------------
package sbd_pkg;

    // Depth of the character class table, one entry per character code.
    localparam int TABLE_DEPTH = 256;

    // Request commands.
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_DECODE  = 2'd1;
    localparam logic [1:0] CMD_FLUSH   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Class codes held in the table; anything above the pad code is illegal.
    localparam logic [6:0] CLASS_END     = 7'd64;
    localparam logic [6:0] CLASS_PAD     = 7'd65;
    localparam logic [6:0] CLASS_ILLEGAL = 7'd66;

    // Result kinds.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef logic [6:0] class_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } result_t;

    // Up to three results produced by one request.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } result_group_t;

endpackage

[hdl/sbd_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage array and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/sbd_class_table.sv]
// ----------------------------------------------------------------------------
// Character class table
// RAM of class codes with one valid bit per entry; an entry never loaded
// since reset reads as the illegal class.
// ----------------------------------------------------------------------------
module sbd_class_table #(
    parameter int TABLE_DEPTH = sbd_pkg::TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  sbd_pkg::class_t                wr_class,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output sbd_pkg::class_t                rd_class
);
    import sbd_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   hit_reg;
    class_t                 ram_q;

    sbd_ram #(
        .WIDTH ($bits(class_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_class),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Valid bits are cleared at reset and set by a load.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // The valid bit is sampled alongside the RAM read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (rd_en) begin
            hit_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_class = hit_reg ? ram_q : CLASS_ILLEGAL;

endmodule

[hdl/sbd_decode.sv]
// ----------------------------------------------------------------------------
// Six-bit decode stage
// Holds the request whose class has been read, updates the accumulator and
// builds the group of results for that request.
// ----------------------------------------------------------------------------
module sbd_decode (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    input  logic [1:0]             in_cmd,
    input  sbd_pkg::class_t        cls,
    input  logic                   out_free,
    output logic                   in_ready,
    output logic                   advance,
    output sbd_pkg::result_group_t group
);
    import sbd_pkg::*;

    logic        valid_reg;
    logic [1:0]  cmd_reg;
    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;

    logic [23:0]   shifted;
    result_t [2:0] pend;
    logic [1:0]    pend_n;
    result_t       err_res;

    function automatic result_t data_res(input logic [7:0] b);
        result_t r;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        return r;
    endfunction

    assign err_res  = '{kind: KIND_ERROR, data_byte: 8'd0};
    assign advance  = valid_reg && out_free;
    assign in_ready = !valid_reg || out_free;

    // Request register in front of the decode logic.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg <= in_cmd;
        end
    end

    // Bytes held by two or three pending values.
    always_comb begin
        pend   = '0;
        pend_n = 2'd0;
        case (cnt_reg)
            2'd2: begin
                pend[0] = data_res(acc_reg[11:4]);
                pend_n  = 2'd1;
            end
            2'd3: begin
                pend[0] = data_res(acc_reg[17:10]);
                pend[1] = data_res(acc_reg[9:2]);
                pend_n  = 2'd2;
            end
            default: begin
                pend_n = 2'd0;
            end
        endcase
    end

    // Decode of one request: next state and its results.
    always_comb begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        group       = '0;
        shifted     = {acc_reg, cls[5:0]};
        case (cmd_reg)
            CMD_RESTART: begin
                acc_next = '0;
                cnt_next = 2'd0;
                fin_next = 1'b0;
            end
            CMD_FLUSH: begin
                if (!fin_reg) begin
                    group.res   = pend;
                    group.count = pend_n;
                    acc_next    = '0;
                    cnt_next    = 2'd0;
                end
            end
            CMD_DECODE: begin
                if (!fin_reg) begin
                    if (cls < CLASS_END) begin
                        if (cnt_reg == 2'd3) begin
                            group.res[0] = data_res(shifted[23:16]);
                            group.res[1] = data_res(shifted[15:8]);
                            group.res[2] = data_res(shifted[7:0]);
                            group.count  = 2'd3;
                            acc_next     = '0;
                            cnt_next     = 2'd0;
                        end else begin
                            acc_next = shifted[17:0];
                            cnt_next = cnt_reg + 2'd1;
                        end
                    end else begin
                        // End, pad and illegal all finish the run.
                        fin_next = 1'b1;
                        acc_next = '0;
                        cnt_next = 2'd0;
                        if (cls == CLASS_END) begin
                            if (cnt_reg != 2'd0) begin
                                group.res         = pend;
                                group.res[pend_n] = err_res;
                                group.count       = pend_n + 2'd1;
                            end
                        end else if (cls == CLASS_PAD && cnt_reg >= 2'd2) begin
                            group.res   = pend;
                            group.count = pend_n;
                        end else begin
                            group.res[0] = err_res;
                            group.count  = 2'd1;
                        end
                    end
                end
            end
            default: begin
                // Table loads are handled at acceptance.
                group = '0;
            end
        endcase
    end

    // Decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= 2'd0;
            fin_reg <= 1'b0;
        end else if (advance) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            fin_reg <= fin_next;
        end
    end

    // A finished decoder stays silent until restarted.
    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && fin_reg && (cmd_reg == CMD_DECODE || cmd_reg == CMD_FLUSH))
        |-> group.count == 2'd0)
        else $error("finished decoder produced results");

    // Restart clears the pending count and the finished flag.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && cmd_reg == CMD_RESTART) |=> (cnt_reg == 2'd0 && !fin_reg))
        else $error("restart did not clear decoder state");

    // Three results come from a completed group of four values, or from an
    // end mark after three values (two bytes and the error).
    a_full_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && group.count == 2'd3)
        |-> (cmd_reg == CMD_DECODE && cnt_reg == 2'd3 && cls <= CLASS_END))
        else $error("three results without three pending values");

endmodule

[hdl/sbd_out_buf.sv]
// ----------------------------------------------------------------------------
// Result buffer
// Output register holding up to three results, handed out one per m_ transfer.
// ----------------------------------------------------------------------------
module sbd_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sbd_pkg::result_group_t group,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import sbd_pkg::*;

    result_t [2:0] entry_reg;
    logic [1:0]    rem_reg;
    logic          pop;

    assign pop  = m_tvalid && m_tready;
    assign free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);

    // Remaining result count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else if (push) begin
            rem_reg <= group.count;
        end else if (pop) begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    // Result entries; the head moves down on every delivered result.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg <= group.res;
        end else if (pop) begin
            entry_reg[0] <= entry_reg[1];
            entry_reg[1] <= entry_reg[2];
        end
    end

    assign m_tvalid = rem_reg != 2'd0;
    assign m_tdata  = entry_reg[0].data_byte;
    assign m_tuser  = entry_reg[0].kind;
    assign m_tlast  = rem_reg == 2'd1;

    // A new group only lands once the previous one is fully delivered.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (rem_reg == 2'd0 || (rem_reg == 2'd1 && pop)))
        else $error("result group overwritten");

    // An error result always closes its group.
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tlast && m_tdata == 8'd0))
        else $error("error result not final or not zero");

endmodule

[hdl/table_driven_six_bit_decoder.sv]
// ----------------------------------------------------------------------------
// Table-driven six-bit decoder
// Decodes base64 or uuencode style text through a loadable class table.
//
//   Channel | Direction | tuser          | tdata                         | tlast
//   s_      | in        | cmd[1:0]       | char_code[7:0], class_value   | -
//           |           |                | [14:8], zero [15]             |
//   m_      | out       | kind           | data_byte[7:0]                | last
//
// A request is accepted in any cycle in which the decode stage is free; the
// class table read and the request register load at the accepting edge, and
// the decode logic then fills the result register once it is free, from which
// the first result is offered.
// A request yielding n results holds the result register until all n are sent
// (one result per cycle while m_tready is high), so one request per cycle is
// sustained while each gives at most one result and m_tready stays high.
// Reset clears the table's valid bits at once; no clearing pass is needed.
// Back-pressure on m_ stalls the decode stage and then s_tready.
// ----------------------------------------------------------------------------
module table_driven_six_bit_decoder #(
    parameter int TABLE_DEPTH = sbd_pkg::TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[7:0], class_value[14:8], zero[15]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // data_byte[7:0]
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast
);
    import sbd_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic                   in_accept;
    logic [ADDR_W-1:0]      addr;
    class_t                 cls;
    logic                   out_free;
    logic                   advance;
    result_group_t          group;

    assign in_accept = s_tvalid && s_tready;
    assign addr      = s_tdata[ADDR_W-1:0];

    // Class table: loads write at acceptance, every request reads.
    sbd_class_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_accept && s_tuser == CMD_LOAD),
        .wr_addr  (addr),
        .wr_class (s_tdata[14:8]),
        .rd_en    (in_accept),
        .rd_addr  (addr),
        .rd_class (cls)
    );

    sbd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_cmd    (s_tuser),
        .cls       (cls),
        .out_free  (out_free),
        .in_ready  (s_tready),
        .advance   (advance),
        .group     (group)
    );

    sbd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (advance),
        .group    (group),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[bench/tb_table_driven_six_bit_decoder.sv]
// ----------------------------------------------------------------------------
// Six-bit decoder testbench
// Drives load, decode, flush and restart requests into the table-driven
// decoder with random gaps on both channels. A scoreboard predicts every
// byte and error result from its own copy of the class table and decoder
// state, and checks each result the block returns in order.
// ----------------------------------------------------------------------------
module tb_table_driven_six_bit_decoder;

    import sbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_QUOTA = 30;
    localparam int SIDE_SEND   = 0;
    localparam int SIDE_RECV   = 1;

    // Class above the illegal code; the block must treat it as illegal.
    localparam class_t CLASS_WILD = 7'd127;

    // Characters used by the directed requests.
    localparam logic [7:0] CH_ZERO = 8'h41;
    localparam logic [7:0] CH_TOP  = 8'hFF;
    localparam logic [7:0] CH_PAD  = 8'h3D;
    localparam logic [7:0] CH_END  = 8'h2E;
    localparam logic [7:0] CH_WILD = 8'h7F;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last;
    } decoded_t;

    // Scoreboard: predicts results per request and checks those returned.
    class decode_book;
        class_t      class_tbl [TABLE_DEPTH];
        logic [23:0] acc;
        int          nvals;
        bit          done;
        decoded_t    expected_q [$];
        int          failures;
        int          loads;
        int          data_total;
        int          error_total;

        function new();
            foreach (class_tbl[i]) class_tbl[i] = CLASS_ILLEGAL;
            acc = '0;
            nvals = 0;
            done = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        function void add_result(logic kind, logic [7:0] value);
            decoded_t r;
            r.kind = kind;
            r.data_byte = value;
            r.last = 1'b0;
            expected_q.push_back(r);
            if (kind == KIND_DATA) data_total++;
            else error_total++;
        endfunction

        // Turn the pending values into whole bytes and clear them.
        function void release_bytes();
            case (nvals)
                2: add_result(KIND_DATA, acc[11:4]);
                3: begin
                    add_result(KIND_DATA, acc[17:10]);
                    add_result(KIND_DATA, acc[9:2]);
                end
                4: begin
                    add_result(KIND_DATA, acc[23:16]);
                    add_result(KIND_DATA, acc[15:8]);
                    add_result(KIND_DATA, acc[7:0]);
                end
                default: ;
            endcase
            acc = '0;
            nvals = 0;
        endfunction

        // Note an accepted request; returns 0 when the block ignores it.
        function bit note_request(logic [1:0] cmd, logic [7:0] code, class_t cls);
            int     prior_count;
            class_t entry;
            prior_count = expected_q.size();
            case (cmd)
                CMD_LOAD: begin
                    class_tbl[code] = cls;
                    loads++;
                end
                CMD_RESTART: begin
                    acc = '0;
                    nvals = 0;
                    done = 1'b0;
                end
                CMD_FLUSH: begin
                    if (done) return 1'b0;
                    release_bytes();
                end
                default: begin
                    if (done) return 1'b0;
                    entry = class_tbl[code];
                    if (entry < CLASS_END) begin
                        acc = {acc[17:0], entry[5:0]};
                        nvals++;
                        if (nvals == 4) release_bytes();
                    end else if (entry == CLASS_END) begin
                        done = 1'b1;
                        if (nvals != 0) begin
                            release_bytes();
                            add_result(KIND_ERROR, 8'h00);
                        end
                    end else if (entry == CLASS_PAD) begin
                        done = 1'b1;
                        if (nvals >= 2) begin
                            release_bytes();
                        end else begin
                            acc = '0;
                            nvals = 0;
                            add_result(KIND_ERROR, 8'h00);
                        end
                    end else begin
                        // Illegal or out-of-range class drops pending values.
                        done = 1'b1;
                        acc = '0;
                        nvals = 0;
                        add_result(KIND_ERROR, 8'h00);
                    end
                end
            endcase
            if (expected_q.size() > prior_count)
                expected_q[expected_q.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        function void check_result(logic kind, logic [7:0] value, logic last);
            decoded_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h last=%0d",
                                 kind, value, last));
                return;
            end
            want = expected_q.pop_front();
            if (want.kind !== kind || want.data_byte !== value || want.last !== last)
                report($sformatf("expected k=%0d b=%02h l=%0d, got k=%0d b=%02h l=%0d",
                                 want.kind, want.data_byte, want.last,
                                 kind, value, last));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    decode_book  book = new();
    int unsigned cycle_count = 0;
    int          calm_left [2] = '{0, 0};
    int          requests_sent = 0;
    int          acted_count = 0;
    int          frames = 0;
    logic [7:0]  alpha_base;
    logic [7:0]  end_code;
    logic [7:0]  pad_code;

    table_driven_six_bit_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, book.pending());
        $display("simulation failed");
        $finish;
    end

    // Idle cycles before the next request: mostly random, with calm stretches.
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Offer one request and wait for it to be taken; tvalid stays high after.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] code,
                                input class_t cls);
        int gap;
        gap = draw_gap(SIDE_SEND);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, cls, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        if (book.note_request(cmd, code, cls)) acted_count++;
    endtask

    // Hold off new requests until every predicted result has been returned.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send_value();
        send_request(CMD_DECODE, 8'(alpha_base + $urandom_range(0, 63)),
                     class_t'($urandom_range(0, 127)));
    endtask

    task automatic send_mark(input logic [7:0] code);
        send_request(CMD_DECODE, code, class_t'($urandom_range(0, 127)));
    endtask

    task automatic send_flush();
        send_request(CMD_FLUSH, 8'($urandom_range(0, 255)),
                     class_t'($urandom_range(0, 127)));
    endtask

    task automatic load_alphabet(input logic [7:0] base, input logic [7:0] end_c,
                                 input logic [7:0] pad_c);
        int v;
        for (v = 0; v < 64; v++) send_request(CMD_LOAD, 8'(base + v), class_t'(v));
        send_request(CMD_LOAD, end_c, CLASS_END);
        send_request(CMD_LOAD, pad_c, CLASS_PAD);
        alpha_base = base;
        end_code   = end_c;
        pad_code   = pad_c;
    endtask

    // A well-formed encoded frame with a random ending.
    task automatic send_frame();
        int groups;
        int tail;
        int n;
        send_request(CMD_RESTART, 8'($urandom_range(0, 255)),
                     class_t'($urandom_range(0, 127)));
        groups = $urandom_range(0, 3);
        repeat (groups) begin
            repeat (4) send_value();
            if ($urandom_range(0, 3) == 0) send_flush();
        end
        tail = $urandom_range(0, 5);
        case (tail)
            0: send_mark(end_code);
            1: begin
                repeat (2) send_value();
                send_mark(pad_code);
            end
            2: begin
                repeat (3) send_value();
                send_mark(pad_code);
            end
            3: begin
                n = $urandom_range(2, 3);
                repeat (n) send_value();
                send_flush();
                send_mark(end_code);
            end
            4: begin
                n = $urandom_range(1, 3);
                repeat (n) send_value();
                send_mark(end_code);
            end
            default: begin
                n = $urandom_range(0, 1);
                repeat (n) send_value();
                send_mark(pad_code);
            end
        endcase
        frames++;
    endtask

    // Raw requests, table scribbles and frames broken by a stray character.
    task automatic send_noise();
        int n;
        case ($urandom_range(0, 2))
            0: send_request(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                            class_t'($urandom_range(0, 127)));
            1: send_request(CMD_LOAD, 8'(8'hE0 + $urandom_range(0, 31)),
                            class_t'($urandom_range(0, 127)));
            default: begin
                send_request(CMD_RESTART, 8'($urandom_range(0, 255)),
                             class_t'($urandom_range(0, 127)));
                n = $urandom_range(0, 3);
                repeat (n) send_value();
                send_mark(8'(8'hE0 + $urandom_range(0, 31)));
            end
        endcase
    endtask

    task automatic run_phase(input int quota);
        int start;
        start = acted_count;
        while (acted_count - start < quota) begin
            if ($urandom_range(0, 9) < 7) send_frame();
            else send_noise();
        end
    endtask

    // Result side: random stalls on m_tready.
    initial begin
        int gap;
        wait (aresetn == 1'b1);
        forever begin
            gap = draw_gap(SIDE_RECV);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_result(m_tuser, m_tdata, m_tlast);
    end

    // Main sequence.
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fresh table is all illegal, then ignored requests.
        send_request(CMD_DECODE, CH_ZERO, '0);
        send_request(CMD_FLUSH, CH_ZERO, '0);
        // Extremes of the value range, both marks and an out-of-range class.
        send_request(CMD_LOAD, CH_ZERO, 7'd0);
        send_request(CMD_LOAD, CH_TOP, 7'd63);
        send_request(CMD_LOAD, CH_PAD, CLASS_PAD);
        send_request(CMD_LOAD, CH_END, CLASS_END);
        send_request(CMD_LOAD, CH_WILD, CLASS_WILD);
        // Flushes with nothing, one value, then two values pending.
        send_request(CMD_RESTART, CH_ZERO, '0);
        send_request(CMD_FLUSH, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_FLUSH, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_ZERO, '0);
        send_request(CMD_FLUSH, CH_ZERO, '0);
        // A full group of four values.
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_ZERO, '0);
        // Out-of-range class with a value pending.
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_WILD, '0);
        // End mark after three values: two bytes, then the error.
        send_request(CMD_RESTART, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_TOP, '0);
        send_request(CMD_DECODE, CH_END, '0);
        // Early pad after a single value.
        send_request(CMD_RESTART, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_PAD, '0);
        // Quiet end, then a character that must be ignored.
        send_request(CMD_RESTART, CH_ZERO, '0);
        send_request(CMD_DECODE, CH_END, '0);
        send_request(CMD_DECODE, CH_ZERO, '0);

        // Random frames over two different alphabets.
        quiesce();
        load_alphabet(8'h80, 8'hC0, 8'hC1);
        run_phase(PHASE_QUOTA);
        quiesce();
        load_alphabet(8'h20, 8'h0A, 8'h60);
        run_phase(PHASE_QUOTA);

        // Drain and allow any stray trailing results to show up.
        quiesce();
        repeat (24) @(posedge aclk);
        if (book.pending() != 0)
            book.report($sformatf("%0d predicted results never arrived", book.pending()));

        $display("Run covered %0d requests, %0d of them table loads, and %0d encoded frames",
                 requests_sent, book.loads, frames);
        $display("over two alphabets, with %0d data bytes and %0d error results checked.",
                 book.data_total, book.error_total);
        if (book.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches in total", book.failures);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/sbd_pkg.sv
hdl/sbd_ram.sv
hdl/sbd_class_table.sv
hdl/sbd_decode.sv
hdl/sbd_out_buf.sv
hdl/table_driven_six_bit_decoder.sv
bench/tb_table_driven_six_bit_decoder.sv
